FILE: hdl/gne_pkg.sv
// shared constants, tables and control types of the grid neighbour expander
package gne_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int COORD_W   = $clog2(MAX_SIDE);
    localparam int SIDE_W    = COORD_W + 1;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int NBR_N     = 8;
    localparam int NBR_IDX_W = $clog2(NBR_N);
    localparam int COST_W    = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [COST_W-1:0] COST_STRAIGHT = 8'd160;
    localparam logic [COST_W-1:0] COST_DIAGONAL = 8'd226;
    localparam logic [SIDE_W-1:0] SIDE_RESET    = SIDE_W'(MAX_SIDE);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_EXPAND = 1'b1;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [1:0] OFF_M = 2'd0;
    localparam logic [1:0] OFF_Z = 2'd1;
    localparam logic [1:0] OFF_P = 2'd2;

    // neighbour order: column outer, row inner, centre skipped
    localparam logic [1:0] NBR_DX [NBR_N] =
        '{OFF_M, OFF_M, OFF_M, OFF_Z, OFF_Z, OFF_P, OFF_P, OFF_P};
    localparam logic [1:0] NBR_DY [NBR_N] =
        '{OFF_M, OFF_Z, OFF_P, OFF_M, OFF_P, OFF_M, OFF_Z, OFF_P};

    // orthogonal cells beside each diagonal: same row, same column
    localparam logic [NBR_IDX_W-1:0] ORTH_ROW [NBR_N] =
        '{3'd1, 3'd0, 3'd1, 3'd0, 3'd0, 3'd6, 3'd0, 3'd6};
    localparam logic [NBR_IDX_W-1:0] ORTH_COL [NBR_N] =
        '{3'd3, 3'd0, 3'd4, 3'd0, 3'd0, 3'd3, 3'd0, 3'd4};

    typedef struct packed {
        logic                 wr_en;
        logic                 start;
        logic                 rd_en;
        logic [NBR_IDX_W-1:0] rd_idx;
        logic                 eval;
        logic                 emit;
    } gne_cmd_t;

    typedef struct packed {
        logic out_free;
        logic pick_last;
    } gne_status_t;

endpackage

FILE: hdl/gne_if.sv
// valid/ready channel interfaces for map items and neighbour results
interface gne_item_if;
    import gne_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               blocked;

    modport source (output valid, func, cell_x, cell_y, blocked, input ready);
    modport sink   (input valid, func, cell_x, cell_y, blocked, output ready);
endinterface

interface gne_result_if;
    import gne_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [COORD_W-1:0] nbr_x;
    logic [COORD_W-1:0] nbr_y;
    logic [COST_W-1:0]  step_cost;
    logic               last;

    modport source (output valid, found, nbr_x, nbr_y, step_cost, last, input ready);
    modport sink   (input valid, found, nbr_x, nbr_y, step_cost, last, output ready);
endinterface

FILE: hdl/grid_neighbour_expander.sv
// top level of the grid neighbour expander
//
//  channel  kind       role   contents
//  cmd      valid/rdy  sink   func, cell_x, cell_y, blocked
//  res      valid/rdy  source found, nbr_x, nbr_y, step_cost, last
//  apb      apb write  slave  grid_width at 0x0, grid_height at 0x4
//
// a write is done in idle; a query reads the window, then emits each result
// the eight window reads go through the single read port of the map
// one query at a time; the next transaction is taken while the last result waits
// a stalled result holds the emission; no clearing pass after reset
module grid_neighbour_expander (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gne_pkg::APB_AW-1:0] paddr,
    input  logic [gne_pkg::APB_DW-1:0] pwdata,
    output logic [gne_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    gne_item_if.sink                   cmd,
    gne_result_if.source               res
);
    import gne_pkg::*;

    logic [SIDE_W-1:0] width_eff;
    logic [SIDE_W-1:0] height_eff;
    gne_cmd_t          ctrl_cmd;
    gne_status_t       dp_status;

    gne_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .width_eff  (width_eff),
        .height_eff (height_eff)
    );

    gne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_func  (cmd.func),
        .in_ready (cmd.ready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    gne_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .status        (dp_status),
        .width_eff     (width_eff),
        .height_eff    (height_eff),
        .cell_x        (cmd.cell_x),
        .cell_y        (cmd.cell_y),
        .blocked       (cmd.blocked),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .out_found     (res.found),
        .out_nbr_x     (res.nbr_x),
        .out_nbr_y     (res.nbr_y),
        .out_step_cost (res.step_cost),
        .out_last      (res.last)
    );

endmodule

FILE: hdl/gne_regs.sv
// apb register file holding the grid size
module gne_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gne_pkg::APB_AW-1:0] paddr,
    input  logic [gne_pkg::APB_DW-1:0] pwdata,
    output logic [gne_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [gne_pkg::SIDE_W-1:0] width_eff,
    output logic [gne_pkg::SIDE_W-1:0] height_eff
);
    import gne_pkg::*;

    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_RESET;
            height_reg <= SIDE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  width_reg  <= pwdata[SIDE_W-1:0];
                REG_GRID_HEIGHT: height_reg <= pwdata[SIDE_W-1:0];
                default:         width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = APB_DW'(width_reg);
            REG_GRID_HEIGHT: prdata = APB_DW'(height_reg);
            default:         prdata = '0;
        endcase
    end

    // sizes above the store saturate
    assign width_eff  = (width_reg  > SIDE_RESET) ? SIDE_RESET : width_reg;
    assign height_eff = (height_reg > SIDE_RESET) ? SIDE_RESET : height_reg;

endmodule

FILE: hdl/gne_ctrl.sv
// controller sequencing map writes, window reads and result emission
module gne_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_func,
    output logic                 in_ready,
    input  gne_pkg::gne_status_t status,
    output gne_pkg::gne_cmd_t    cmd
);
    import gne_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [NBR_IDX_W-1:0] cnt_reg;
    logic [NBR_IDX_W-1:0] cnt_next;
    logic                 accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_en = accept && (in_func == FUNC_WRITE);
                cmd.start = accept && (in_func == FUNC_EXPAND);
                if (cmd.start)
                begin
                    state_next = ST_READ;
                    cnt_next   = '0;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = cnt_reg;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == NBR_IDX_W'(NBR_N - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free && status.pick_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hdl/gne_dp.sv
// datapath: obstacle map, 3x3 window, neighbour mask and result register
module gne_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gne_pkg::gne_cmd_t           cmd,
    output gne_pkg::gne_status_t        status,
    input  logic [gne_pkg::SIDE_W-1:0]  width_eff,
    input  logic [gne_pkg::SIDE_W-1:0]  height_eff,
    input  logic [gne_pkg::COORD_W-1:0] cell_x,
    input  logic [gne_pkg::COORD_W-1:0] cell_y,
    input  logic                        blocked,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_found,
    output logic [gne_pkg::COORD_W-1:0] out_nbr_x,
    output logic [gne_pkg::COORD_W-1:0] out_nbr_y,
    output logic [gne_pkg::COST_W-1:0]  out_step_cost,
    output logic                        out_last
);
    import gne_pkg::*;

    function automatic logic [COORD_W-1:0] step_coord(
        input logic [COORD_W-1:0] c,
        input logic [1:0]         off
    );
        logic [COORD_W-1:0] r;
        case (off)
            OFF_M:   r = c - 1'b1;
            OFF_P:   r = c + 1'b1;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic step_inside(
        input logic [COORD_W-1:0] c,
        input logic [1:0]         off,
        input logic [SIDE_W-1:0]  lim
    );
        logic r;
        case (off)
            OFF_M:   r = (c != '0);
            OFF_P:   r = (({1'b0, c} + 1'b1) < lim);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    logic                 map_mem [MAX_SIDE*MAX_SIDE];
    logic [COORD_W-1:0]   cx_reg;
    logic [COORD_W-1:0]   cy_reg;
    logic                 rd_data_reg;
    logic                 rd_vld_reg;
    logic [NBR_IDX_W-1:0] rd_idx_reg;
    logic [NBR_N-1:0]     blk_reg;
    logic [NBR_N-1:0]     mask_reg;
    logic [NBR_N-1:0]     mask_next;
    logic                 out_valid_reg;
    logic                 found_reg;
    logic [COORD_W-1:0]   nx_reg;
    logic [COORD_W-1:0]   ny_reg;
    logic [COST_W-1:0]    cost_reg;
    logic                 last_reg;

    logic [COORD_W-1:0]   nx   [NBR_N];
    logic [COORD_W-1:0]   ny   [NBR_N];
    logic [NBR_N-1:0]     in_grid;
    logic [NBR_N-1:0]     diag;
    logic                 centre_in;
    logic [NBR_IDX_W-1:0] pick_idx;
    logic [NBR_N-1:0]     rest;
    logic [ADDR_W-1:0]    rd_addr;

    always_comb
    begin
        for (int k = 0; k < NBR_N; k++)
        begin
            nx[k]      = step_coord(cx_reg, NBR_DX[k]);
            ny[k]      = step_coord(cy_reg, NBR_DY[k]);
            in_grid[k] = step_inside(cx_reg, NBR_DX[k], width_eff) &&
                         step_inside(cy_reg, NBR_DY[k], height_eff);
            diag[k]    = (NBR_DX[k] != OFF_Z) && (NBR_DY[k] != OFF_Z);
        end
    end

    assign centre_in = ({1'b0, cx_reg} < width_eff) && ({1'b0, cy_reg} < height_eff);
    assign rd_addr   = {ny[cmd.rd_idx], nx[cmd.rd_idx]};

    // map store, one write or one read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            map_mem[{cell_y, cell_x}] <= blocked;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cx_reg <= cell_x;
            cy_reg <= cell_y;
        end
        rd_idx_reg <= cmd.rd_idx;
        if (rd_vld_reg)
        begin
            blk_reg[rd_idx_reg] <= rd_data_reg;
        end
    end

    always_comb
    begin
        pick_idx = '0;
        for (int i = NBR_N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_idx = NBR_IDX_W'(i);
            end
        end
        rest             = mask_reg & ~(NBR_N'(1) << pick_idx);
        status.pick_last = (rest == '0);
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.eval)
        begin
            for (int k = 0; k < NBR_N; k++)
            begin
                mask_next[k] = centre_in && in_grid[k] && !blk_reg[k] &&
                               (!diag[k] || (!blk_reg[ORTH_ROW[k]] && !blk_reg[ORTH_COL[k]]));
            end
        end
        else if (cmd.emit)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            mask_reg   <= mask_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            found_reg <= (mask_reg != '0);
            last_reg  <= status.pick_last;
            if (mask_reg != '0)
            begin
                nx_reg   <= nx[pick_idx];
                ny_reg   <= ny[pick_idx];
                cost_reg <= diag[pick_idx] ? COST_DIAGONAL : COST_STRAIGHT;
            end
            else
            begin
                nx_reg   <= '0;
                ny_reg   <= '0;
                cost_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_found     = found_reg;
    assign out_nbr_x     = nx_reg;
    assign out_nbr_y     = ny_reg;
    assign out_step_cost = cost_reg;
    assign out_last      = last_reg;

endmodule

FILE: hdl/gne_checker.sv
// port-level checks of the grid neighbour expander and their binding
module gne_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       cmd_func,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       res_found,
    input logic                       res_last,
    input logic [gne_pkg::COST_W-1:0] res_step_cost
);
    import gne_pkg::*;

    // a query keeps the block busy while the window is read
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_func == FUNC_EXPAND) |=> !cmd_ready)
        else $error("ready high right after a query transaction");

    // an empty answer is a single final result with zero cost
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_last && (res_step_cost == '0))
        else $error("not-found result malformed");

    a_cost_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_found |->
            (res_step_cost == COST_STRAIGHT) || (res_step_cost == COST_DIAGONAL))
        else $error("unexpected step cost");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_last) && $stable(res_found))
        else $error("stalled result changed");

endmodule

bind grid_neighbour_expander gne_checker u_gne_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .cmd_func      (cmd.func),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_found     (res.found),
    .res_last      (res.last),
    .res_step_cost (res.step_cost)
);

FILE: dv/tb_grid_neighbour_expander.sv
// self-checking testbench for the grid neighbour expander: directed table, then random map traffic
`timescale 1ns / 1ps

module tb_grid_neighbour_expander;
    import gne_pkg::*;

    typedef struct packed {
        logic              found;
        logic [COORD_W-1:0] nbr_x;
        logic [COORD_W-1:0] nbr_y;
        logic [COST_W-1:0]  step_cost;
        logic              last;
    } nbr_result_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_WIDTH, ROW_HEIGHT} row_kind_t;

    // arg: blocked flag for writes, register value for register rows
    typedef struct packed {
        row_kind_t          kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIDE_W-1:0]  arg;
        logic               typed;
        nbr_result_t        want;
    } probe_row_t;

    localparam nbr_result_t NO_WANT   = '0;
    localparam nbr_result_t NOT_FOUND = '{1'b0, 6'd0, 6'd0, 8'd0, 1'b1};
    localparam nbr_result_t CORNER_HIT = '{1'b1, 6'd0, 6'd1, COST_STRAIGHT, 1'b1};

    localparam int PROBE_N = 27;
    localparam probe_row_t PROBES [PROBE_N] = '{
        // corner of the map at reset size
        '{ROW_WRITE,  6'd0,  6'd0,  7'd0,   1'b0, NO_WANT},
        '{ROW_WRITE,  6'd1,  6'd0,  7'd1,   1'b0, NO_WANT},
        '{ROW_WRITE,  6'd0,  6'd1,  7'd0,   1'b0, NO_WANT},
        '{ROW_WRITE,  6'd1,  6'd1,  7'd0,   1'b0, NO_WANT},
        '{ROW_QUERY,  6'd0,  6'd0,  7'd0,   1'b1, CORNER_HIT},
        '{ROW_WRITE,  6'd2,  6'd0,  7'd0,   1'b0, NO_WANT},
        '{ROW_WRITE,  6'd2,  6'd1,  7'd1,   1'b0, NO_WANT},
        '{ROW_QUERY,  6'd1,  6'd0,  7'd0,   1'b0, NO_WANT},
        // far corner: both sides blocked, diagonal cut off
        '{ROW_WRITE,  6'd62, 6'd62, 7'd0,   1'b0, NO_WANT},
        '{ROW_WRITE,  6'd62, 6'd63, 7'd1,   1'b0, NO_WANT},
        '{ROW_WRITE,  6'd63, 6'd62, 7'd1,   1'b0, NO_WANT},
        '{ROW_WRITE,  6'd63, 6'd63, 7'd0,   1'b0, NO_WANT},
        '{ROW_QUERY,  6'd63, 6'd63, 7'd0,   1'b1, NOT_FOUND},
        '{ROW_QUERY,  6'd62, 6'd63, 7'd0,   1'b0, NO_WANT},
        // small grid, centre outside it
        '{ROW_WIDTH,  6'd0,  6'd0,  7'd3,   1'b0, NO_WANT},
        '{ROW_HEIGHT, 6'd0,  6'd0,  7'd2,   1'b0, NO_WANT},
        '{ROW_QUERY,  6'd5,  6'd1,  7'd0,   1'b1, NOT_FOUND},
        '{ROW_QUERY,  6'd1,  6'd1,  7'd0,   1'b0, NO_WANT},
        '{ROW_QUERY,  6'd2,  6'd1,  7'd0,   1'b0, NO_WANT},
        // empty grid
        '{ROW_WIDTH,  6'd0,  6'd0,  7'd0,   1'b0, NO_WANT},
        '{ROW_QUERY,  6'd0,  6'd0,  7'd0,   1'b1, NOT_FOUND},
        // oversized registers saturate
        '{ROW_WIDTH,  6'd0,  6'd0,  7'd127, 1'b0, NO_WANT},
        '{ROW_HEIGHT, 6'd0,  6'd0,  7'd127, 1'b0, NO_WANT},
        '{ROW_QUERY,  6'd63, 6'd63, 7'd0,   1'b1, NOT_FOUND},
        '{ROW_QUERY,  6'd1,  6'd0,  7'd0,   1'b0, NO_WANT},
        '{ROW_WIDTH,  6'd0,  6'd0,  7'd64,  1'b0, NO_WANT},
        '{ROW_HEIGHT, 6'd0,  6'd0,  7'd64,  1'b0, NO_WANT}
    };

    localparam int PHASE_N = 7;
    localparam int PHASE_W [PHASE_N]        = '{64, 5, 1, 64, 127, 0, 23};
    localparam int PHASE_H [PHASE_N]        = '{64, 4, 64, 1, 127, 3, 64};
    localparam int PHASE_SRC_GAP [PHASE_N]  = '{25, 0, 40, 15, 30, 10, 0};
    localparam int PHASE_SINK_GAP [PHASE_N] = '{20, 35, 0, 40, 15, 25, 0};
    localparam int ITEMS_PER_PHASE = 14;
    localparam int SETTLE_CYCLES   = 30;
    localparam int LONG_HOLD       = 80;
    localparam int QUIET_LIMIT     = 4000;
    localparam int REPORT_CAP      = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    gne_item_if   item_ch ();
    gne_result_if nbr_ch ();

    grid_neighbour_expander uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (item_ch),
        .res     (nbr_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bit                map_shadow [MAX_SIDE*MAX_SIDE];
    bit                map_known  [MAX_SIDE*MAX_SIDE];
    logic [SIDE_W-1:0] grid_w = SIDE_RESET;
    logic [SIDE_W-1:0] grid_h = SIDE_RESET;
    nbr_result_t       pending_nbrs [$];

    int  errors = 0;
    int  n_items = 0;
    int  n_writes = 0;
    int  n_queries = 0;
    int  n_results = 0;
    int  n_empty = 0;
    int  src_gap_pct = 20;
    int  sink_gap_pct = 20;
    bit  hold_results = 1'b0;

    function automatic int side_in_use(input logic [SIDE_W-1:0] v);
        return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    function automatic bit is_wall(input int x, input int y);
        return map_shadow[y * MAX_SIDE + x];
    endfunction

    // free neighbours of a centre, column outer and row inner
    function automatic void expand_cell(input logic [COORD_W-1:0] cx, cy);
        int          w;
        int          h;
        int          rx;
        int          ry;
        bit          diag;
        bit          have;
        nbr_result_t held;
        nbr_result_t hit;
        w = side_in_use(grid_w);
        h = side_in_use(grid_h);
        have = 1'b0;
        held = NO_WANT;
        if (int'(cx) < w && int'(cy) < h)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                for (int dy = -1; dy <= 1; dy++)
                begin
                    rx = int'(cx) + dx;
                    ry = int'(cy) + dy;
                    diag = (dx != 0) && (dy != 0);
                    if ((dx != 0 || dy != 0) && rx >= 0 && ry >= 0 && rx < w && ry < h
                        && !is_wall(rx, ry)
                        && !(diag && (is_wall(rx, int'(cy)) || is_wall(int'(cx), ry))))
                    begin
                        hit.found     = 1'b1;
                        hit.nbr_x     = rx[COORD_W-1:0];
                        hit.nbr_y     = ry[COORD_W-1:0];
                        hit.step_cost = diag ? COST_DIAGONAL : COST_STRAIGHT;
                        hit.last      = 1'b0;
                        if (have)
                            pending_nbrs = {pending_nbrs, held};
                        held = hit;
                        have = 1'b1;
                    end
                end
            end
        end
        if (have)
            held.last = 1'b1;
        else
            held = NOT_FOUND;
        pending_nbrs = {pending_nbrs, held};
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int side,
                                                      input logic [COORD_W-1:0] anchor);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel == 2)
            return COORD_W'(side > 0 ? side - 1 : 0);
        if (sel == 3)
            return COORD_W'(side);
        if (sel <= 5)
            return COORD_W'($urandom_range(0, MAX_SIDE - 1));
        return anchor + COORD_W'($urandom_range(0, 3));
    endfunction

    task automatic send_item(input logic f, input logic [COORD_W-1:0] x, y, input logic b);
        int gap;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.func    <= f;
        item_ch.cell_x  <= x;
        item_ch.cell_y  <= y;
        item_ch.blocked <= b;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        n_items++;
    endtask

    task automatic send_write(input logic [COORD_W-1:0] x, y, input logic b);
        send_item(FUNC_WRITE, x, y, b);
        map_shadow[{y, x}] = b;
        map_known[{y, x}]  = 1'b1;
        n_writes++;
    endtask

    // every cell the query window may touch, wrapped, is written first
    task automatic fill_window(input logic [COORD_W-1:0] cx, cy);
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
        for (int dx = -1; dx <= 1; dx++)
        begin
            for (int dy = -1; dy <= 1; dy++)
            begin
                wx = cx + COORD_W'(dx);
                wy = cy + COORD_W'(dy);
                if (!map_known[{wy, wx}])
                    send_write(wx, wy, $urandom_range(0, 99) < 35);
            end
        end
    endtask

    task automatic send_query(input logic [COORD_W-1:0] x, y, input bit typed,
                              input nbr_result_t want);
        fill_window(x, y);
        send_item(FUNC_EXPAND, x, y, 1'($urandom_range(0, 1)));
        n_queries++;
        if (typed)
            pending_nbrs = {pending_nbrs, want};
        else
            expand_cell(x, y);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_nbrs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic sel, input logic [SIDE_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= APB_DW'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_GRID_WIDTH)
            grid_w = val;
        else
            grid_h = val;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            if (errors < REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        nbr_result_t want;
        if (rst_n && nbr_ch.valid && nbr_ch.ready)
        begin
            n_results++;
            if (!nbr_ch.found)
                n_empty++;
            if (pending_nbrs.size() == 0)
            begin
                if (errors < REPORT_CAP)
                    $error("unexpected result transaction x=%0d y=%0d",
                           nbr_ch.nbr_x, nbr_ch.nbr_y);
                errors++;
            end
            else
            begin
                want = pending_nbrs.pop_front();
                check_field("found", want.found, nbr_ch.found);
                check_field("nbr_x", want.nbr_x, nbr_ch.nbr_x);
                check_field("nbr_y", want.nbr_y, nbr_ch.nbr_y);
                check_field("step_cost", want.step_cost, nbr_ch.step_cost);
                check_field("last", want.last, nbr_ch.last);
            end
        end
    end

    initial
    begin : result_sink
        nbr_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                nbr_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_results = 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_gap_pct)
            begin
                nbr_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                nbr_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (nbr_ch.valid && nbr_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_nbrs.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        probe_row_t         row;
        int                 phase_start;
        int                 pick;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] anchor_x;
        logic [COORD_W-1:0] anchor_y;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        item_ch.valid   = 1'b0;
        item_ch.func    = FUNC_WRITE;
        item_ch.cell_x  = '0;
        item_ch.cell_y  = '0;
        item_ch.blocked = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PROBE_N; i++)
        begin
            row = PROBES[i];
            case (row.kind)
                ROW_WRITE:
                    send_write(row.x, row.y, row.arg[0]);
                ROW_QUERY:
                    send_query(row.x, row.y, row.typed, row.want);
                ROW_WIDTH:
                begin
                    wait_idle();
                    set_register(REG_GRID_WIDTH, row.arg);
                end
                default:
                begin
                    wait_idle();
                    set_register(REG_GRID_HEIGHT, row.arg);
                end
            endcase
        end

        for (int p = 0; p < PHASE_N; p++)
        begin
            wait_idle();
            set_register(REG_GRID_WIDTH, SIDE_W'(PHASE_W[p]));
            set_register(REG_GRID_HEIGHT, SIDE_W'(PHASE_H[p]));
            src_gap_pct  = PHASE_SRC_GAP[p];
            sink_gap_pct = PHASE_SINK_GAP[p];
            anchor_x = COORD_W'($urandom_range(0, side_in_use(grid_w) > 3 ?
                                                   side_in_use(grid_w) - 3 : 0));
            anchor_y = COORD_W'($urandom_range(0, side_in_use(grid_h) > 3 ?
                                                   side_in_use(grid_h) - 3 : 0));
            // result side stalls while queries keep coming
            if (p == 0)
                hold_results = 1'b1;
            phase_start = n_items;
            while (n_items - phase_start < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                cx = pick_coord(side_in_use(grid_w), anchor_x);
                cy = pick_coord(side_in_use(grid_h), anchor_y);
                if (pick < 7)
                begin
                    // reshape the window around a centre, then expand it
                    repeat ($urandom_range(0, 4))
                        send_write(cx + COORD_W'($urandom_range(0, 2) - 1),
                                   cy + COORD_W'($urandom_range(0, 2) - 1),
                                   $urandom_range(0, 99) < 35);
                    send_query(cx, cy, 1'b0, NO_WANT);
                end
                else if (pick == 7)
                    send_write(cx, cy, 1'($urandom_range(0, 1)));
                else
                    send_query(cx, cy, 1'b0, NO_WANT);
            end
        end

        wait_idle();
        $display("covered %0d map writes and %0d queries over %0d grid settings",
                 n_writes, n_queries, PHASE_N + 4);
        $display("checked %0d neighbour results, %0d of them with no free neighbour",
                 n_results, n_empty);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
